[sv/owsrc_pkg.sv]
// Shared definitions for the 1-Wire relay slave: transaction phases, command codes,
// relay read weights and the Maxim CRC8 byte step.
// No dependencies.
package owsrc_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ROMCMD = 4'd1,
    PH_SEARCH = 4'd2,
    PH_MATCH  = 4'd3,
    PH_FUNC   = 4'd4,
    PH_READ   = 4'd5,
    PH_WRITE  = 4'd6
  } phase_t;

  localparam logic [7:0] CMD_SEARCH = 8'hF0;
  localparam logic [7:0] CMD_MATCH  = 8'h55;
  localparam logic [7:0] CMD_READ   = 8'hA0;
  localparam logic [7:0] CMD_WRITE  = 8'hB0;

  localparam int unsigned ROM_SERIAL_W = 56;
  localparam int unsigned RELAY_COUNT  = 4;
  localparam logic [ROM_SERIAL_W-1:0] ROM_SERIAL_RESET = 56'h01_0100_0000_00F1;

  // Reflected Maxim polynomial.
  localparam logic [7:0] CRC8_POLY = 8'h8C;

  // Byte sent in a read for an energized relay; zero when it is off.
  function automatic logic [7:0] relay_weight(input logic [1:0] idx);
    logic [7:0] w;
    unique case (idx)
      2'd0: w = 8'h08;
      2'd1: w = 8'h10;
      2'd2: w = 8'h01;
      2'd3: w = 8'h04;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

  // One data byte through the CRC8, LSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc;
    d = data;
    for (int n = 0; n < 8; n++) begin
      fb = c[0] ^ d[0];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CRC8_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

[sv/onewire_slave_relay_controller.sv]
// 1-Wire slave relay controller: slot-level protocol engine, ROM CRC unit and relay bank.
// Depends on owsrc_pkg.
//
// This block is the protocol side of a 1-Wire slave that drives four relays. Each transfer
// on the input channel is one bus event already timed by the bus front end: mode low means
// a reset pulse was seen, mode high means one bit time slot, with line_sample giving the bus
// level mid-slot. Every input transfer yields exactly one output transfer: hold_low tells
// the front end to pull the line low in this slot (presence pulse after a reset, or a
// written zero), relay_outputs is the relay state after the event, and active is high
// while a transaction is still open. The slave supports Search ROM, Match ROM followed by
// the Read (0xA0) and Write (0xB0) function commands; Write only updates the relays when
// the trailing CRC8 matches. Timing: an event is registered at the input, decoded in
// combinational logic and registered at the output, and one event is accepted every
// clock while the output side keeps up. Writing rom_serial starts a CRC8 calculation
// for ROM byte 7, one byte per cycle; the input channel is stalled until it completes
// after reset and after each register write, so a new serial applies to the very next
// event, even in the middle of a bus transaction. Write the register only while no
// transfer is in flight.
module onewire_slave_relay_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [owsrc_pkg::ROM_SERIAL_W-1:0]   cfg_data,
  // Bus event input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic                                 line_sample,
  // Result output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 hold_low,
  output logic [owsrc_pkg::RELAY_COUNT-1:0]    relay_outputs,
  output logic                                 active
);

  // ROM image and its CRC byte.
  logic [owsrc_pkg::ROM_SERIAL_W-1:0] rom_serial;
  logic [7:0]                         rom_crc;
  logic [2:0]                         crc_count;
  logic                               crc_ready;
  logic [63:0]                        rom_image;

  // Input register.
  logic s1_valid;
  logic s1_mode;
  logic s1_line;
  logic s1_advance;
  logic out_free;

  // Protocol state.
  owsrc_pkg::phase_t phase, phase_next;
  logic [1:0] search_substep, search_substep_next;
  logic [5:0] bit_index, bit_index_next;
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] crc_accum, crc_accum_next;
  logic [3:0] pending_relays, pending_relays_next;
  logic [3:0] relay_state, relay_state_next;

  // Shared decode terms.
  logic [7:0] rx_shift;
  logic [5:0] bit_inc;
  logic       byte_done;
  logic       rom_bit;
  logic [7:0] rom_byte_sel;
  logic [7:0] tx_byte;
  logic       tx_bit;
  logic       hold_next;

  // The ROM bytes 0..6 come from the register, byte 7 from the CRC unit.
  assign rom_image = {rom_crc, rom_serial};

  // The CRC of the seven ROM bytes is worked out one byte per cycle after reset and after
  // each register write. A count of seven means the CRC is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_serial <= owsrc_pkg::ROM_SERIAL_RESET;
      rom_crc    <= 8'h00;
      crc_count  <= 3'd0;
    end else if (cfg_write) begin
      rom_serial <= cfg_data;
      rom_crc    <= 8'h00;
      crc_count  <= 3'd0;
    end else if (crc_count != 3'd7) begin
      rom_crc   <= owsrc_pkg::crc8_step(rom_crc, rom_image[{crc_count, 3'b000} +: 8]);
      crc_count <= crc_count + 3'd1;
    end
  end

  assign crc_ready = (crc_count == 3'd7);

  // The output register can take a new result when it is empty or being emptied. No event
  // is taken in while the ROM CRC is still being worked out.
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = (s1_valid && !out_free) || !crc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode <= mode;
      s1_line <= line_sample;
    end
  end

  // Terms shared by the next-state and output logic. A received bit shifts in from the
  // top, LSB first; a byte is complete on the eighth bit.
  assign rx_shift     = {s1_line, shift_byte[7:1]};
  assign bit_inc      = bit_index + 6'd1;
  assign byte_done    = (bit_inc >= 6'd8);
  assign rom_bit      = rom_image[bit_index];
  assign rom_byte_sel = rom_image[{byte_index[2:0], 3'b000} +: 8];
  assign tx_byte      = (byte_index < 4'd4)
                        ? (relay_state[byte_index[1:0]]
                           ? owsrc_pkg::relay_weight(byte_index[1:0]) : 8'h00)
                        : crc_accum;
  assign tx_bit       = tx_byte[bit_index[2:0]];

  // Next-state logic for one event.
  always_comb begin
    phase_next          = phase;
    search_substep_next = search_substep;
    bit_index_next      = bit_index;
    byte_index_next     = byte_index;
    shift_byte_next     = shift_byte;
    crc_accum_next      = crc_accum;
    pending_relays_next = pending_relays;
    relay_state_next    = relay_state;

    if (!s1_mode) begin
      // A bus reset aborts anything in progress and opens a new ROM command.
      phase_next          = owsrc_pkg::PH_ROMCMD;
      search_substep_next = 2'd0;
      bit_index_next      = 6'd0;
      byte_index_next     = 4'd0;
      shift_byte_next     = 8'h00;
    end else begin
      unique case (phase)
        owsrc_pkg::PH_ROMCMD: begin
          shift_byte_next = rx_shift;
          bit_index_next  = byte_done ? 6'd0 : bit_inc;
          if (byte_done) begin
            if (rx_shift == owsrc_pkg::CMD_SEARCH) begin
              phase_next          = owsrc_pkg::PH_SEARCH;
              search_substep_next = 2'd0;
            end else if (rx_shift == owsrc_pkg::CMD_MATCH) begin
              phase_next      = owsrc_pkg::PH_MATCH;
              byte_index_next = 4'd0;
            end else begin
              phase_next          = owsrc_pkg::PH_IDLE;
              search_substep_next = 2'd0;
              byte_index_next     = 4'd0;
            end
          end
        end
        owsrc_pkg::PH_SEARCH: begin
          // Write the bit, write its complement, then read the master's choice.
          if (search_substep == 2'd0) begin
            search_substep_next = 2'd1;
          end else if (search_substep == 2'd1) begin
            search_substep_next = 2'd2;
          end else if ((s1_line != rom_bit) || (bit_index == 6'd63)) begin
            phase_next          = owsrc_pkg::PH_IDLE;
            search_substep_next = 2'd0;
            bit_index_next      = 6'd0;
            byte_index_next     = 4'd0;
          end else begin
            search_substep_next = 2'd0;
            bit_index_next      = bit_inc;
          end
        end
        owsrc_pkg::PH_MATCH: begin
          shift_byte_next = rx_shift;
          bit_index_next  = byte_done ? 6'd0 : bit_inc;
          if (byte_done) begin
            if (rx_shift != rom_byte_sel) begin
              phase_next          = owsrc_pkg::PH_IDLE;
              search_substep_next = 2'd0;
              byte_index_next     = 4'd0;
            end else if (byte_index >= 4'd7) begin
              phase_next      = owsrc_pkg::PH_FUNC;
              byte_index_next = 4'd0;
            end else begin
              byte_index_next = byte_index + 4'd1;
            end
          end
        end
        owsrc_pkg::PH_FUNC: begin
          shift_byte_next = rx_shift;
          bit_index_next  = byte_done ? 6'd0 : bit_inc;
          if (byte_done) begin
            byte_index_next = 4'd0;
            crc_accum_next  = 8'h00;
            if (rx_shift == owsrc_pkg::CMD_READ) begin
              phase_next = owsrc_pkg::PH_READ;
            end else if (rx_shift == owsrc_pkg::CMD_WRITE) begin
              phase_next          = owsrc_pkg::PH_WRITE;
              pending_relays_next = 4'h0;
            end else begin
              phase_next          = owsrc_pkg::PH_IDLE;
              search_substep_next = 2'd0;
            end
          end
        end
        owsrc_pkg::PH_READ: begin
          bit_index_next = byte_done ? 6'd0 : bit_inc;
          if (byte_done) begin
            if (byte_index < 4'd4) begin
              crc_accum_next  = owsrc_pkg::crc8_step(crc_accum, tx_byte);
              byte_index_next = byte_index + 4'd1;
            end else begin
              phase_next          = owsrc_pkg::PH_IDLE;
              search_substep_next = 2'd0;
              byte_index_next     = 4'd0;
            end
          end
        end
        owsrc_pkg::PH_WRITE: begin
          shift_byte_next = rx_shift;
          bit_index_next  = byte_done ? 6'd0 : bit_inc;
          if (byte_done) begin
            if (byte_index < 4'd4) begin
              if (rx_shift != 8'h00) begin
                pending_relays_next = pending_relays | (4'b0001 << byte_index[1:0]);
              end
              crc_accum_next  = owsrc_pkg::crc8_step(crc_accum, rx_shift);
              byte_index_next = byte_index + 4'd1;
            end else begin
              // The relays only take the new value when the CRC byte agrees.
              if (rx_shift == crc_accum) begin
                relay_state_next = pending_relays;
              end
              phase_next          = owsrc_pkg::PH_IDLE;
              search_substep_next = 2'd0;
              byte_index_next     = 4'd0;
            end
          end
        end
        default: begin
          // Idle: slots are ignored until the next bus reset.
          phase_next          = owsrc_pkg::PH_IDLE;
          search_substep_next = 2'd0;
          bit_index_next      = 6'd0;
          byte_index_next     = 4'd0;
        end
      endcase
    end
  end

  // Line drive for this event. A written one leaves the line released.
  always_comb begin
    hold_next = 1'b0;
    if (!s1_mode) begin
      hold_next = 1'b1;
    end else begin
      unique case (phase)
        owsrc_pkg::PH_SEARCH: begin
          if (search_substep == 2'd0) begin
            hold_next = !rom_bit;
          end else if (search_substep == 2'd1) begin
            hold_next = rom_bit;
          end
        end
        owsrc_pkg::PH_READ: hold_next = !tx_bit;
        default:            hold_next = 1'b0;
      endcase
    end
  end

  // State advances once per event, as the event moves into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= owsrc_pkg::PH_IDLE;
      search_substep <= 2'd0;
      bit_index      <= 6'd0;
      byte_index     <= 4'd0;
      shift_byte     <= 8'h00;
      crc_accum      <= 8'h00;
      pending_relays <= 4'h0;
      relay_state    <= 4'h0;
    end else if (s1_advance) begin
      phase          <= phase_next;
      search_substep <= search_substep_next;
      bit_index      <= bit_index_next;
      byte_index     <= byte_index_next;
      shift_byte     <= shift_byte_next;
      crc_accum      <= crc_accum_next;
      pending_relays <= pending_relays_next;
      relay_state    <= relay_state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      hold_low      <= hold_next;
      relay_outputs <= relay_state_next;
      active        <= (phase_next != owsrc_pkg::PH_IDLE);
    end
  end

  // The relays never change without an event being processed.
  a_relay_stable: assert property (@(posedge clk) disable iff (rst)
    !s1_advance |=> $stable(relay_state))
    else $error("relay state changed without an event");

  // A bus reset event always yields a presence pulse and an open transaction.
  a_reset_presence: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !s1_mode) |=> (out_valid && hold_low && active))
    else $error("bus reset not answered with presence");

  // Outside Search ROM the bit counter never leaves the current byte.
  a_bit_in_byte: assert property (@(posedge clk) disable iff (rst)
    (phase != owsrc_pkg::PH_SEARCH) |-> (bit_index < 6'd8))
    else $error("bit index out of range outside search");

  // Idle leaves all counters cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == owsrc_pkg::PH_IDLE) |->
      (search_substep == 2'd0 && bit_index == 6'd0 && byte_index == 4'd0))
    else $error("counters not cleared while idle");

endmodule
